### sv/wsft_pkg.sv
// ----------------------------------------------------------------------------
// wsft_pkg
// Shared constants and types for the window stack and focus table.
// ----------------------------------------------------------------------------
`default_nettype none

package wsft_pkg;

	localparam int NUM_SLOTS    = 32;
	localparam int SURFACE_BITS = 8;
	localparam int DEPTH_W      = 8;
	localparam int IDX_W        = $clog2(NUM_SLOTS);

	localparam logic [7:0] THR_RESET = 8'd90;

	// operation codes
	localparam logic [2:0] OP_REGISTER   = 3'd0;
	localparam logic [2:0] OP_UNREGISTER = 3'd1;
	localparam logic [2:0] OP_FOCUS      = 3'd2;
	localparam logic [2:0] OP_MINIMIZE   = 3'd3;
	localparam logic [2:0] OP_RESTORE    = 3'd4;
	localparam logic [2:0] OP_TOGGLE     = 3'd5;
	localparam logic [2:0] OP_QUERY      = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_DEPTH  = 2'd1;
	localparam logic [1:0] KIND_VIS    = 2'd2;

	// register indexes
	localparam logic REG_THRESHOLD = 1'b0;

	// one slot entry as held in the slot memory
	typedef struct packed {
		logic                    minimized;
		logic [DEPTH_W-1:0]      depth;
		logic [SURFACE_BITS-1:0] surface;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### sv/wsft_ram.sv
// ----------------------------------------------------------------------------
// wsft_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wsft_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 17
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/window_stack_focus_table_core.sv
// ----------------------------------------------------------------------------
// window_stack_focus_table_core
// Window slot table with stacking depths, minimise state and focus tracking.
// ----------------------------------------------------------------------------
//  channel   signals                                      direction
//  command   start, busy, opcode, surface_id              in (busy out)
//  result    strobe, kind, target_surface, depth_value,   out
//            visible, ok, active_valid, focus_id, last
//  config    psel, penable, pwrite, paddr, pwdata,        APB
//            prdata, pready
//
//  A command is taken when start is high and busy low. Slot fields live in a
//  one-port-read memory, so every search is a sweep over all NUM_SLOTS
//  entries. A refocus adds one sweep to the lookup sweep. A renumbering
//  runs one selection sweep per shown window plus one. Results last one
//  cycle each and cannot be stalled. Reset clears in-use flags and focus
//  and sets the depth counter to 1 at once.
// ----------------------------------------------------------------------------
`default_nettype none

module window_stack_focus_table_core
	import wsft_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output      logic                    busy,
	input  wire logic [2:0]              opcode,
	input  wire logic [SURFACE_BITS-1:0] surface_id,
	output      logic                    strobe,
	output      logic [1:0]              kind,
	output      logic [SURFACE_BITS-1:0] target_surface,
	output      logic [DEPTH_W-1:0]      depth_value,
	output      logic                    visible,
	output      logic                    ok,
	output      logic                    active_valid,
	output      logic [SURFACE_BITS-1:0] focus_id,
	output      logic                    last,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [2:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output      logic [31:0]             prdata,
	output      logic                    pready
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DISPATCH, S_RAISE, S_RN_WR, S_RN_END, S_RAISE_WR, S_STATUS
	} state_t;

	typedef enum logic [1:0] { SC_FIND, SC_SELECT, SC_FOCUS } scan_t;

	state_t                  state_q;
	scan_t                   scan_q;
	logic [IDX_W:0]          ptr_q;
	logic                    vld_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [2:0]              op_q;
	logic [SURFACE_BITS-1:0] sid_q;
	logic                    hit_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    min_q;
	logic [DEPTH_W-1:0]      dep_q;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_q;
	logic                    ok_q;
	logic [DEPTH_W-1:0]      cnt_q;
	logic [SURFACE_BITS-1:0] focus_surf_q;
	logic                    focus_v_q;
	logic [7:0]              thr_q;
	logic [NUM_SLOTS-1:0]    used_q;
	logic [NUM_SLOTS-1:0]    done_q;
	logic [IDX_W:0]          rank_q;
	logic                    best_found_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic [DEPTH_W-1:0]      best_dep_q;
	logic [SURFACE_BITS-1:0] best_surf_q;

	logic                    we;
	logic [IDX_W-1:0]        waddr;
	entry_t                  wentry;
	logic                    re;
	logic [ENTRY_W-1:0]      rdata;
	entry_t                  rentry;
	logic                    scan_last;
	logic                    shown_rd;
	logic [DEPTH_W:0]        next_cnt;
	logic [DEPTH_W-1:0]      rank_dep;
	logic                    focus_hit;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? {24'd0, thr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_THRESHOLD) begin
			thr_q <= pwdata[7:0];
		end
	end

	// slot memory
	assign re     = (state_q == S_SCAN) && (ptr_q < (IDX_W+1)'(NUM_SLOTS));
	assign rentry = entry_t'(rdata);

	wsft_ram #(
		.DEPTH(NUM_SLOTS),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.re   (re),
		.raddr(ptr_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	assign scan_last = vld_s1 && (idx_s1 == IDX_W'(NUM_SLOTS - 1));
	assign shown_rd  = used_q[idx_s1] && !rentry.minimized;
	assign next_cnt  = {1'b0, cnt_q} + (DEPTH_W+1)'(1);
	assign rank_dep  = DEPTH_W'(rank_q) + DEPTH_W'(1);
	assign focus_hit = focus_v_q && (focus_surf_q == sid_q);
	assign busy      = (state_q != S_IDLE);

	// memory write selection
	always_comb begin
		we     = 1'b0;
		waddr  = idx_q;
		wentry = '{minimized: 1'b0, depth: dep_q, surface: sid_q};
		case (state_q)
			S_DISPATCH: begin
				case (op_q)
					OP_REGISTER: begin
						we     = !hit_q && free_found_q;
						waddr  = free_q;
						wentry = '{minimized: 1'b0, depth: '0, surface: sid_q};
					end
					OP_FOCUS:    we = hit_q && min_q;
					OP_MINIMIZE: begin
						we               = hit_q;
						wentry.minimized = 1'b1;
					end
					OP_RESTORE:  we = hit_q;
					OP_TOGGLE: begin
						we               = hit_q;
						wentry.minimized = !min_q;
					end
					default: we = 1'b0;
				endcase
			end
			S_RN_WR: begin
				we     = 1'b1;
				waddr  = best_idx_q;
				wentry = '{minimized: 1'b0, depth: rank_dep, surface: best_surf_q};
			end
			S_RAISE_WR: begin
				we           = 1'b1;
				wentry.depth = cnt_q;
			end
			default: we = 1'b0;
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			scan_q       <= SC_FIND;
			ptr_q        <= '0;
			vld_s1       <= 1'b0;
			used_q       <= '0;
			done_q       <= '0;
			cnt_q        <= DEPTH_W'(1);
			focus_surf_q <= '0;
			focus_v_q    <= 1'b0;
			strobe       <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			vld_s1 <= re;
			idx_s1 <= ptr_q[IDX_W-1:0];
			if (re) begin
				ptr_q <= ptr_q + (IDX_W+1)'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q         <= opcode;
						sid_q        <= surface_id;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						ptr_q        <= '0;
						scan_q       <= SC_FIND;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					// consume one entry per cycle
					if (vld_s1) begin
						case (scan_q)
							SC_FIND: begin
								if (used_q[idx_s1] && rentry.surface == sid_q && !hit_q) begin
									hit_q <= 1'b1;
									idx_q <= idx_s1;
									min_q <= rentry.minimized;
									dep_q <= rentry.depth;
								end
								if (!used_q[idx_s1] && !free_found_q) begin
									free_found_q <= 1'b1;
									free_q       <= idx_s1;
								end
							end
							SC_SELECT: begin
								if (shown_rd && !done_q[idx_s1] &&
								    (!best_found_q || rentry.depth < best_dep_q)) begin
									best_found_q <= 1'b1;
									best_idx_q   <= idx_s1;
									best_dep_q   <= rentry.depth;
									best_surf_q  <= rentry.surface;
								end
							end
							SC_FOCUS: begin
								if (shown_rd && (!best_found_q || rentry.depth > best_dep_q)) begin
									best_found_q <= 1'b1;
									best_idx_q   <= idx_s1;
									best_dep_q   <= rentry.depth;
									best_surf_q  <= rentry.surface;
								end
							end
							default: ;
						endcase
					end
					if (scan_last) begin
						case (scan_q)
							SC_FIND:   state_q <= S_DISPATCH;
							SC_SELECT: state_q <= best_found_q ? S_RN_WR : S_RN_END;
							default:   state_q <= S_STATUS;
						endcase
						// the last entry may itself be the best one
						if (scan_q == SC_SELECT && shown_rd && !done_q[idx_s1] &&
						    (!best_found_q || rentry.depth < best_dep_q)) begin
							state_q <= S_RN_WR;
						end
						if (scan_q == SC_FOCUS) begin
							if (shown_rd && (!best_found_q || rentry.depth > best_dep_q)) begin
								focus_v_q    <= 1'b1;
								focus_surf_q <= rentry.surface;
							end else begin
								focus_v_q    <= best_found_q;
								focus_surf_q <= best_found_q ? best_surf_q : '0;
							end
						end
					end
				end
				S_DISPATCH: begin
					ok_q    <= hit_q;
					state_q <= S_STATUS;
					case (op_q)
						OP_REGISTER: begin
							ok_q <= 1'b0;
							if (!hit_q && free_found_q) begin
								used_q[free_q] <= 1'b1;
								idx_q          <= free_q;
								ok_q           <= 1'b1;
								state_q        <= S_RAISE;
							end
						end
						OP_UNREGISTER: begin
							if (hit_q) begin
								used_q[idx_q] <= 1'b0;
								if (focus_hit) begin
									ptr_q        <= '0;
									best_found_q <= 1'b0;
									scan_q       <= SC_FOCUS;
									state_q      <= S_SCAN;
								end
							end
						end
						OP_FOCUS: begin
							if (hit_q) begin
								state_q <= S_RAISE;
								if (min_q) begin
									strobe         <= 1'b1;
									kind           <= KIND_VIS;
									target_surface <= sid_q;
									depth_value    <= '0;
									visible        <= 1'b1;
									ok             <= 1'b0;
									active_valid   <= 1'b0;
									focus_id       <= '0;
									last           <= 1'b0;
								end
							end
						end
						OP_MINIMIZE, OP_RESTORE, OP_TOGGLE: begin
							if (hit_q) begin
								strobe         <= 1'b1;
								kind           <= KIND_VIS;
								target_surface <= sid_q;
								depth_value    <= '0;
								ok             <= 1'b0;
								active_valid   <= 1'b0;
								focus_id       <= '0;
								last           <= 1'b0;
								if (op_q == OP_RESTORE || (op_q == OP_TOGGLE && min_q)) begin
									visible <= 1'b1;
									state_q <= S_RAISE;
								end else begin
									visible <= 1'b0;
									if (focus_hit) begin
										ptr_q        <= '0;
										best_found_q <= 1'b0;
										scan_q       <= SC_FOCUS;
										state_q      <= S_SCAN;
									end
								end
							end
						end
						OP_QUERY: ;
						default:  ok_q <= 1'b0;
					endcase
				end
				S_RAISE: begin
					// step the counter, or renumber when it passes the threshold
					if (next_cnt > {1'b0, thr_q} || next_cnt > (DEPTH_W+1)'(255)) begin
						done_q       <= '0;
						rank_q       <= '0;
						ptr_q        <= '0;
						best_found_q <= 1'b0;
						scan_q       <= SC_SELECT;
						state_q      <= S_SCAN;
					end else begin
						cnt_q   <= next_cnt[DEPTH_W-1:0];
						state_q <= S_RAISE_WR;
					end
				end
				S_RN_WR: begin
					strobe             <= 1'b1;
					kind               <= KIND_DEPTH;
					target_surface     <= best_surf_q;
					depth_value        <= rank_dep;
					visible            <= 1'b0;
					ok                 <= 1'b0;
					active_valid       <= 1'b0;
					focus_id           <= '0;
					last               <= 1'b0;
					done_q[best_idx_q] <= 1'b1;
					rank_q             <= rank_q + (IDX_W+1)'(1);
					ptr_q              <= '0;
					best_found_q       <= 1'b0;
					state_q            <= S_SCAN;
				end
				S_RN_END: begin
					cnt_q   <= rank_dep;
					state_q <= S_RAISE_WR;
				end
				S_RAISE_WR: begin
					strobe         <= 1'b1;
					kind           <= KIND_DEPTH;
					target_surface <= sid_q;
					depth_value    <= cnt_q;
					visible        <= 1'b0;
					ok             <= 1'b0;
					active_valid   <= 1'b0;
					focus_id       <= '0;
					last           <= 1'b0;
					focus_surf_q   <= sid_q;
					focus_v_q      <= 1'b1;
					state_q        <= S_STATUS;
				end
				S_STATUS: begin
					strobe         <= 1'b1;
					kind           <= KIND_STATUS;
					target_surface <= sid_q;
					depth_value    <= '0;
					visible        <= 1'b0;
					ok             <= ok_q;
					active_valid   <= focus_v_q;
					focus_id       <= focus_v_q ? focus_surf_q : '0;
					last           <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/tb_window_stack_focus_table_core.sv
// ----------------------------------------------------------------------------
// tb_window_stack_focus_table_core
// Self-checking bench for the window stack and focus table. Commands are
// driven through the start/busy handshake and every result word is compared
// field by field against a cycle-free predictor of the slot table, focus and
// depth counter. A short directed table opens the run; random phases follow,
// each under its own renumber threshold written over APB while idle.
// ----------------------------------------------------------------------------
module tb_window_stack_focus_table_core;
	timeunit 1ns;
	timeprecision 1ps;
	import wsft_pkg::*;

	localparam logic [2:0] OP_SPARE = 3'd7;	// unassigned opcode
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int SETTLE_CYCLES    = 40;
	localparam int POOL_SIZE        = 40;

	// one result word
	typedef struct {
		logic [1:0] kind;
		logic [7:0] tgt;
		logic [7:0] depth;
		logic       vis;
		logic       ok;
		logic       act_valid;
		logic [7:0] act_surf;
		logic       last;
	} word_t;

	// directed row; status typed in where obvious
	typedef struct {
		logic [2:0] op;
		logic [7:0] sid;
		bit         typed;
		bit         ok;
		bit         act_valid;
		logic [7:0] act_surf;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] opcode = '0;
	logic [SURFACE_BITS-1:0] surface_id = '0;
	logic strobe;
	logic [1:0] kind;
	logic [SURFACE_BITS-1:0] target_surface;
	logic [DEPTH_W-1:0] depth_value;
	logic visible, ok, active_valid, last;
	logic [SURFACE_BITS-1:0] focus_id;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	window_stack_focus_table_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted table state
	bit         slot_used [NUM_SLOTS];
	logic [7:0] slot_surf [NUM_SLOTS];
	logic [7:0] slot_dep  [NUM_SLOTS];
	bit         slot_min  [NUM_SLOTS];
	logic [7:0] focus_surf;
	bit         focus_ok;
	logic [7:0] depth_ctr;
	logic [7:0] threshold;

	word_t awaited_words [$];
	int errors = 0;
	int items_sent = 0;
	int words_seen = 0;
	int renumbers = 0;
	logic [7:0] sid_pool [POOL_SIZE];

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		errors++;
	endtask

	function automatic void push_word(logic [1:0] k, logic [7:0] t, logic [7:0] d, logic v);
		word_t w;
		w = '{k, t, d, v, 1'b0, 1'b0, 8'd0, 1'b0};
		awaited_words.push_back(w);
	endfunction

	function automatic int slot_of(logic [7:0] s);
		for (int i = 0; i < NUM_SLOTS; i++)
			if (slot_used[i] && slot_surf[i] == s) return i;
		return -1;
	endfunction

	function automatic bit is_shown(int i);
		return slot_used[i] && !slot_min[i];
	endfunction

	// compact the shown windows to depths 1..count, ties by slot index
	function automatic void renumber_shown();
		int rank [NUM_SLOTS];
		int cnt;
		cnt = 0;
		renumbers++;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			rank[i] = -1;
			if (is_shown(i)) begin
				cnt++;
				rank[i] = 0;
				for (int j = 0; j < NUM_SLOTS; j++)
					if (is_shown(j) && j != i && (slot_dep[j] < slot_dep[i] ||
					    (slot_dep[j] == slot_dep[i] && j < i)))
						rank[i]++;
			end
		end
		for (int r = 0; r < cnt; r++)
			for (int i = 0; i < NUM_SLOTS; i++)
				if (is_shown(i) && rank[i] == r) begin
					slot_dep[i] = 8'(r + 1);
					push_word(KIND_DEPTH, slot_surf[i], 8'(r + 1), 1'b0);
				end
		depth_ctr = 8'(cnt + 1);
	endfunction

	function automatic void raise_window(int i);
		int nv;
		nv = int'(depth_ctr) + 1;
		if (nv > int'(threshold) || nv > 255) renumber_shown();
		else depth_ctr = 8'(nv);
		slot_dep[i] = depth_ctr;
		push_word(KIND_DEPTH, slot_surf[i], depth_ctr, 1'b0);
		focus_surf = slot_surf[i];
		focus_ok = 1'b1;
	endfunction

	// focus goes to the deepest shown window, lowest slot on a tie
	function automatic void pick_focus();
		int best;
		best = -1;
		for (int i = 0; i < NUM_SLOTS; i++)
			if (is_shown(i) && (best < 0 || slot_dep[i] > slot_dep[best])) best = i;
		focus_ok = (best >= 0);
		focus_surf = (best >= 0) ? slot_surf[best] : 8'd0;
	endfunction

	function automatic void hide_window(int i);
		slot_min[i] = 1'b1;
		push_word(KIND_VIS, slot_surf[i], 8'd0, 1'b0);
		if (focus_ok && focus_surf == slot_surf[i]) pick_focus();
	endfunction

	function automatic void show_and_raise(int i);
		slot_min[i] = 1'b0;
		push_word(KIND_VIS, slot_surf[i], 8'd0, 1'b1);
		raise_window(i);
	endfunction

	// expected words for one accepted command
	function automatic void predict_table_op(logic [2:0] op, logic [7:0] s);
		int i, k;
		bit st;
		word_t w;
		i = slot_of(s);
		st = (i >= 0);
		case (op)
			OP_REGISTER: begin
				st = 1'b0;
				if (i < 0) begin
					k = 0;
					while (k < NUM_SLOTS && slot_used[k]) k++;
					if (k < NUM_SLOTS) begin
						slot_used[k] = 1'b1;
						slot_surf[k] = s;
						slot_dep[k] = 8'd0;
						slot_min[k] = 1'b0;
						raise_window(k);
						st = 1'b1;
					end
				end
			end
			OP_UNREGISTER: if (i >= 0) begin
				slot_used[i] = 1'b0;
				if (focus_ok && focus_surf == s) pick_focus();
			end
			OP_FOCUS: if (i >= 0) begin
				if (slot_min[i]) begin
					slot_min[i] = 1'b0;
					push_word(KIND_VIS, s, 8'd0, 1'b1);
				end
				raise_window(i);
			end
			OP_MINIMIZE: if (i >= 0) hide_window(i);
			OP_RESTORE: if (i >= 0) show_and_raise(i);
			OP_TOGGLE: if (i >= 0) begin
				if (slot_min[i]) show_and_raise(i);
				else hide_window(i);
			end
			OP_QUERY: ;
			default: st = 1'b0;
		endcase
		w = '{KIND_STATUS, s, 8'd0, 1'b0, st, focus_ok, focus_ok ? focus_surf : 8'd0, 1'b1};
		awaited_words.push_back(w);
	endfunction

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s got %0h want %0h",
			                          words_seen, name, got, want));
	endtask

	// result monitor: strobed words cannot be held off
	always @(posedge clk) begin
		word_t w;
		if (arst_n && strobe === 1'b1) begin
			if (awaited_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind %0d target %0h",
				                          kind, target_surface));
			end else begin
				w = awaited_words.pop_front();
				check_field("kind", 8'(kind), 8'(w.kind));
				check_field("target", target_surface, w.tgt);
				check_field("depth", depth_value, w.depth);
				check_field("visible", 8'(visible), 8'(w.vis));
				check_field("ok", 8'(ok), 8'(w.ok));
				check_field("active_valid", 8'(active_valid), 8'(w.act_valid));
				check_field("focus_id", focus_id, w.act_surf);
				check_field("last", 8'(last), 8'(w.last));
			end
			words_seen++;
		end
	end

	// watchdog on cycles with no traffic at all
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || strobe === 1'b1 || (psel && penable)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("tb_window_stack_focus_table_core: FAIL");
			$finish;
		end
	end

	task automatic send_cmd(logic [2:0] op, logic [7:0] sid);
		start <= 1'b1;
		opcode <= op;
		surface_id <= sid;
		do @(posedge clk); while (busy !== 1'b0);
		predict_table_op(op, sid);
		items_sent++;
	endtask

	task automatic idle_gap(int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// drain, then write the threshold and read it back
	task automatic set_threshold(logic [7:0] v);
		start <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_THRESHOLD, 2'b00};
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		threshold = v;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== v)
			report_mismatch($sformatf("threshold read %0h want %0h", prdata[7:0], v));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [2:0] pick_op(bit climb);
		int r;
		r = $urandom_range(0, 99);
		if (climb && r < 75) return (r < 55) ? OP_FOCUS : OP_TOGGLE;
		if (r < 28) return OP_REGISTER;
		if (r < 43) return OP_UNREGISTER;
		if (r < 56) return OP_FOCUS;
		if (r < 67) return OP_MINIMIZE;
		if (r < 77) return OP_RESTORE;
		if (r < 89) return OP_TOGGLE;
		if (r < 97) return OP_QUERY;
		return OP_SPARE;
	endfunction

	row_t dir_rows [21] = '{
		'{OP_QUERY,      8'd0,   1, 0, 0, 8'd0},
		'{OP_REGISTER,   8'd5,   1, 1, 1, 8'd5},
		'{OP_REGISTER,   8'd5,   1, 0, 1, 8'd5},
		'{OP_REGISTER,   8'd255, 1, 1, 1, 8'd255},
		'{OP_REGISTER,   8'd0,   1, 1, 1, 8'd0},
		'{OP_FOCUS,      8'd5,   1, 1, 1, 8'd5},
		'{OP_MINIMIZE,   8'd5,   1, 1, 1, 8'd0},
		'{OP_MINIMIZE,   8'd5,   0, 0, 0, 8'd0},
		'{OP_RESTORE,    8'd5,   0, 0, 0, 8'd0},
		'{OP_RESTORE,    8'd5,   0, 0, 0, 8'd0},
		'{OP_TOGGLE,     8'd255, 0, 0, 0, 8'd0},
		'{OP_TOGGLE,     8'd255, 0, 0, 0, 8'd0},
		'{OP_MINIMIZE,   8'd0,   0, 0, 0, 8'd0},
		'{OP_FOCUS,      8'd0,   0, 0, 0, 8'd0},
		'{OP_UNREGISTER, 8'd200, 1, 0, 1, 8'd0},
		'{OP_SPARE,      8'd255, 1, 0, 1, 8'd0},
		'{OP_QUERY,      8'd255, 1, 1, 1, 8'd0},
		'{OP_UNREGISTER, 8'd255, 0, 0, 0, 8'd0},
		'{OP_UNREGISTER, 8'd0,   0, 0, 0, 8'd0},
		'{OP_UNREGISTER, 8'd5,   1, 1, 0, 8'd0},
		'{OP_MINIMIZE,   8'd77,  1, 0, 0, 8'd0}
	};

	// phase plan: threshold, items, climb bias for the counter overflow
	logic [7:0] phase_thr [6];
	int phase_len [6] = '{260, 30, 30, 20, 20, 20};
	bit phase_climb [6] = '{1, 0, 0, 0, 0, 0};

	initial begin
		int pct, n;
		logic [7:0] sid;
		for (int i = 0; i < NUM_SLOTS; i++) slot_used[i] = 1'b0;
		focus_surf = 8'd0;
		focus_ok = 1'b0;
		depth_ctr = 8'd1;
		threshold = THR_RESET;
		for (int i = 0; i < POOL_SIZE; i++) sid_pool[i] = 8'($urandom_range(0, 255));
		sid_pool[0] = 8'd0;
		sid_pool[1] = 8'd255;
		phase_thr = '{8'd255, 8'd2, 8'd250, 8'($urandom_range(2, 250)), THR_RESET,
		              8'($urandom_range(2, 20))};

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed part under the reset threshold
		foreach (dir_rows[r]) begin
			send_cmd(dir_rows[r].op, dir_rows[r].sid);
			if (dir_rows[r].typed) begin
				awaited_words[$].ok = dir_rows[r].ok;
				awaited_words[$].act_valid = dir_rows[r].act_valid;
				awaited_words[$].act_surf = dir_rows[r].act_surf;
			end
		end

		// random phases; idling moves from light to heavy to none
		n = 0;
		for (int p = 0; p < 6; p++) begin
			set_threshold(phase_thr[p]);
			for (int k = 0; k < phase_len[p]; k++) begin
				if (phase_climb[p] && $urandom_range(0, 99) < 75)
					sid = sid_pool[$urandom_range(0, 3)];
				else if ($urandom_range(0, 9) < 8)
					sid = sid_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					sid = 8'($urandom_range(0, 255));
				send_cmd(pick_op(phase_climb[p]), sid);
				pct = (n < 127) ? 36 : (n < 254) ? 60 : 0;
				idle_gap(pct);
				n++;
			end
		end

		start <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d commands, %0d result words, %0d renumberings",
		         items_sent, words_seen, renumbers);
		$display("thresholds 90, 255, 2, 250 and random; %0d mismatches", errors);
		if (errors == 0)
			$display("tb_window_stack_focus_table_core: PASS");
		else
			$display("tb_window_stack_focus_table_core: FAIL");
		$finish;
	end

endmodule
